FILE: hw/rtl/usb_config_descriptor_parser_top_defines.svh
// Assertion macros used by the configuration descriptor parser result queue
`ifndef USB_CONFIG_DESCRIPTOR_PARSER_TOP_DEFINES_SVH
`define USB_CONFIG_DESCRIPTOR_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define USBCFG_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define USBCFG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/usbcfg_pkg.sv
// Types and constants shared by the configuration descriptor parser
package usbcfg_pkg;

  localparam logic [7:0] TYPE_INTERFACE = 8'd4;
  localparam logic [7:0] TYPE_ENDPOINT  = 8'd5;
  localparam logic [7:0] IFACE_MIN_LEN  = 8'd9;
  localparam logic [7:0] EP_MIN_LEN     = 8'd7;
  localparam logic [7:0] DESC_MIN_LEN   = 8'd2;
  localparam int         EP_DIR_BIT     = 7;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  typedef enum logic [1:0] {
    REC_IFACE   = 2'd0,
    REC_EP_OUT  = 2'd1,
    REC_EP_IN   = 2'd2,
    REC_SUMMARY = 2'd3
  } rec_kind_t;

  typedef struct packed {
    rec_kind_t   kind;
    logic [2:0]  iface_index;
    logic [1:0]  slot_index;
    logic [7:0]  class_code;
    logic [7:0]  ep_address;
    logic [1:0]  ep_type;
    logic [15:0] ep_max_size;
    logic [3:0]  iface_count;
    logic        last;
  } rec_t;

  // Records produced by one byte, first record in rec_a
  typedef struct packed {
    logic [1:0] num;
    rec_t       rec_a;
    rec_t       rec_b;
  } push_t;

endpackage

FILE: hw/rtl/usb_config_descriptor_parser_top.sv
// USB configuration descriptor parser: input register, parser and result queue
//
// Input channel: one descriptor byte per transaction (in_data_byte), with
// in_end_of_block high on the final byte of a configuration descriptor block.
// Output channel: one record per transaction: interface, OUT endpoint, IN
// endpoint or end summary; out_last marks the final record caused by a byte.
// A byte causes zero, one or two records.
// Throughput: one byte per cycle while in_stall is low. Bytes are registered,
// then judged combinationally and their records written into a four-entry
// result queue. With the queue empty, a record is offered straight from the
// queue once written, so its byte passes the input register and the queue.
// A byte that causes two records needs two output transactions.
// The input register holds its byte while the queue has fewer than two free
// entries, so in_stall rises only once the receiver has stalled long enough
// to leave fewer than two free entries in the queue.
// Reset (synchronous, active low) empties the queue and input register and
// restores the parser to the start of a block.
module usb_config_descriptor_parser_top #(
  parameter int MAX_INTERFACES = 8,
  parameter int EP_SLOTS       = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_block,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_record_kind,
  output logic [2:0]  out_interface_index,
  output logic [1:0]  out_slot_index,
  output logic [7:0]  out_class_code,
  output logic [7:0]  out_ep_address,
  output logic [1:0]  out_ep_type,
  output logic [15:0] out_ep_max_size,
  output logic [3:0]  out_interface_count,
  output logic        out_last
);

  logic              s_valid_r, s_valid_nxt;
  logic [7:0]        s_byte_r;
  logic              s_eob_r;
  logic              room;
  logic              advance;
  logic              in_take;
  usbcfg_pkg::push_t push;
  usbcfg_pkg::rec_t  head;

  assign advance  = s_valid_r && room;
  assign in_stall = s_valid_r && !room;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s_valid_nxt = s_valid_r;
    if (in_take) begin
      s_valid_nxt = 1'b1;
    end else if (advance) begin
      s_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else begin
      s_valid_r <= s_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s_byte_r <= in_data_byte;
      s_eob_r  <= in_end_of_block;
    end
  end

  usbcfg_parser #(
    .MAX_INTERFACES (MAX_INTERFACES),
    .EP_SLOTS       (EP_SLOTS)
  ) u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_valid   (advance),
    .data_byte    (s_byte_r),
    .end_of_block (s_eob_r),
    .push         (push)
  );

  usbcfg_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .room       (room),
    .head_valid (out_valid),
    .head       (head),
    .pop        (!out_stall)
  );

  assign out_record_kind     = head.kind;
  assign out_interface_index = head.iface_index;
  assign out_slot_index      = head.slot_index;
  assign out_class_code      = head.class_code;
  assign out_ep_address      = head.ep_address;
  assign out_ep_type         = head.ep_type;
  assign out_ep_max_size     = head.ep_max_size;
  assign out_interface_count = head.iface_count;
  assign out_last            = head.last;

endmodule

FILE: hw/rtl/usbcfg_parser.sv
// Descriptor boundary tracking and record generation for one byte per step
module usbcfg_parser #(
  parameter int MAX_INTERFACES = 8,
  parameter int EP_SLOTS       = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_valid,
  input  logic [7:0]         data_byte,
  input  logic               end_of_block,
  output usbcfg_pkg::push_t  push
);

  localparam int IFC_W  = $clog2(MAX_INTERFACES + 1);
  localparam int IDX_W  = (MAX_INTERFACES > 1) ? $clog2(MAX_INTERFACES) : 1;
  localparam int SLOT_W = $clog2(EP_SLOTS + 1);

  logic [7:0]        off_r, off_nxt;
  logic [7:0]        len_r, len_nxt;
  logic [7:0]        type_r, type_nxt;
  logic [7:0]        cap_r   [4];
  logic [7:0]        cap_nxt [4];
  logic [IFC_W-1:0]  ifc_r, ifc_nxt;
  logic [IDX_W-1:0]  cur_r, cur_nxt;
  logic              cur_vld_r, cur_vld_nxt;
  logic [SLOT_W-1:0] out_cnt_r   [MAX_INTERFACES];
  logic [SLOT_W-1:0] out_cnt_nxt [MAX_INTERFACES];
  logic [SLOT_W-1:0] in_cnt_r    [MAX_INTERFACES];
  logic [SLOT_W-1:0] in_cnt_nxt  [MAX_INTERFACES];
  logic              halted_r, halted_nxt;

  logic              desc_done;
  logic              desc_vld;
  usbcfg_pkg::rec_t  desc_rec;
  usbcfg_pkg::rec_t  sum_rec;
  logic              ep_is_in;
  logic [SLOT_W-1:0] ep_cnt;
  logic [1:0]        cap_idx;
  logic [3:0]        sum_count;

  always_comb begin
    off_nxt     = off_r;
    len_nxt     = len_r;
    type_nxt    = type_r;
    cap_nxt     = cap_r;
    ifc_nxt     = ifc_r;
    cur_nxt     = cur_r;
    cur_vld_nxt = cur_vld_r;
    out_cnt_nxt = out_cnt_r;
    in_cnt_nxt  = in_cnt_r;
    halted_nxt  = halted_r;
    desc_done   = 1'b0;
    desc_vld    = 1'b0;
    desc_rec    = '0;
    cap_idx     = 2'(off_r - 8'd2);
    ep_is_in    = 1'b0;
    ep_cnt      = '0;

    if (!halted_r) begin
      if (off_r == 8'd0) begin
        len_nxt = data_byte;
        if (data_byte < usbcfg_pkg::DESC_MIN_LEN) begin
          halted_nxt = 1'b1;
        end else begin
          off_nxt = 8'd1;
        end
      end else begin
        if (off_r == 8'd1) begin
          type_nxt = data_byte;
        end else if (off_r <= 8'd5) begin
          cap_nxt[cap_idx] = data_byte;
        end
        if (({1'b0, off_r} + 9'd1) >= {1'b0, len_r}) begin
          desc_done = 1'b1;
          off_nxt   = 8'd0;
        end else begin
          off_nxt = off_r + 8'd1;
        end
      end
    end

    // Judge the descriptor on its final byte, using the bytes just captured
    if (desc_done) begin
      if (type_nxt == usbcfg_pkg::TYPE_INTERFACE) begin
        if (len_r >= usbcfg_pkg::IFACE_MIN_LEN) begin
          desc_vld             = 1'b1;
          desc_rec.kind        = usbcfg_pkg::REC_IFACE;
          desc_rec.iface_index = 3'(ifc_r);
          desc_rec.class_code  = cap_nxt[3];
          cur_nxt              = IDX_W'(ifc_r);
          cur_vld_nxt          = 1'b1;
          ifc_nxt              = ifc_r + IFC_W'(1);
          if (ifc_nxt >= IFC_W'(MAX_INTERFACES)) begin
            halted_nxt = 1'b1;
          end
        end
      end else if (type_nxt == usbcfg_pkg::TYPE_ENDPOINT) begin
        ep_is_in = cap_nxt[0][usbcfg_pkg::EP_DIR_BIT];
        ep_cnt   = ep_is_in ? in_cnt_r[cur_r] : out_cnt_r[cur_r];
        if (len_r >= usbcfg_pkg::EP_MIN_LEN && cur_vld_r &&
            ep_cnt < SLOT_W'(EP_SLOTS)) begin
          desc_vld             = 1'b1;
          desc_rec.kind        = ep_is_in ? usbcfg_pkg::REC_EP_IN : usbcfg_pkg::REC_EP_OUT;
          desc_rec.iface_index = 3'(cur_r);
          desc_rec.slot_index  = 2'(ep_cnt);
          desc_rec.ep_address  = cap_nxt[0];
          desc_rec.ep_type     = cap_nxt[1][1:0];
          desc_rec.ep_max_size = {cap_nxt[3], cap_nxt[2]};
          if (ep_is_in) begin
            in_cnt_nxt[cur_r] = ep_cnt + SLOT_W'(1);
          end else begin
            out_cnt_nxt[cur_r] = ep_cnt + SLOT_W'(1);
          end
        end
      end
    end
    desc_rec.last = !end_of_block;

    sum_count        = 4'(ifc_nxt);
    sum_rec          = '0;
    sum_rec.kind     = usbcfg_pkg::REC_SUMMARY;
    sum_rec.iface_count = sum_count;
    sum_rec.last     = 1'b1;

    // Restore per-block state after the final byte
    if (end_of_block) begin
      off_nxt     = '0;
      len_nxt     = '0;
      type_nxt    = '0;
      ifc_nxt     = '0;
      cur_nxt     = '0;
      cur_vld_nxt = 1'b0;
      halted_nxt  = 1'b0;
      for (int i = 0; i < 4; i++) begin
        cap_nxt[i] = '0;
      end
      for (int i = 0; i < MAX_INTERFACES; i++) begin
        out_cnt_nxt[i] = '0;
        in_cnt_nxt[i]  = '0;
      end
    end

    push.num   = step_valid ? (2'({1'b0, desc_vld}) + 2'({1'b0, end_of_block})) : 2'd0;
    push.rec_a = desc_vld ? desc_rec : sum_rec;
    push.rec_b = sum_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r     <= '0;
      len_r     <= '0;
      type_r    <= '0;
      ifc_r     <= '0;
      cur_r     <= '0;
      cur_vld_r <= 1'b0;
      halted_r  <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        cap_r[i] <= '0;
      end
      for (int i = 0; i < MAX_INTERFACES; i++) begin
        out_cnt_r[i] <= '0;
        in_cnt_r[i]  <= '0;
      end
    end else if (step_valid) begin
      off_r     <= off_nxt;
      len_r     <= len_nxt;
      type_r    <= type_nxt;
      cap_r     <= cap_nxt;
      ifc_r     <= ifc_nxt;
      cur_r     <= cur_nxt;
      cur_vld_r <= cur_vld_nxt;
      halted_r  <= halted_nxt;
      out_cnt_r <= out_cnt_nxt;
      in_cnt_r  <= in_cnt_nxt;
    end
  end

endmodule

FILE: hw/rtl/usbcfg_fifo.sv
// Result queue: takes up to two records a cycle, hands out one per transaction
`include "usb_config_descriptor_parser_top_defines.svh"

module usbcfg_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  usbcfg_pkg::push_t push,
  output logic              room,
  output logic              head_valid,
  output usbcfg_pkg::rec_t  head,
  input  logic              pop
);

  usbcfg_pkg::rec_t                    mem_r [usbcfg_pkg::FIFO_DEPTH];
  logic [usbcfg_pkg::FIFO_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [usbcfg_pkg::FIFO_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [usbcfg_pkg::FIFO_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                                do_pop;

  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign room       = (cnt_r <= usbcfg_pkg::FIFO_CNT_W'(usbcfg_pkg::FIFO_DEPTH - 2));
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + usbcfg_pkg::FIFO_PTR_W'(push.num);
    rd_ptr_nxt = rd_ptr_r + usbcfg_pkg::FIFO_PTR_W'(do_pop);
    cnt_nxt    = cnt_r + usbcfg_pkg::FIFO_CNT_W'(push.num)
                 - usbcfg_pkg::FIFO_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem_r[wr_ptr_r] <= push.rec_a;
    end
    if (push.num == 2'd2) begin
      mem_r[wr_ptr_r + usbcfg_pkg::FIFO_PTR_W'(1)] <= push.rec_b;
    end
  end

  `USBCFG_ASSERT_IMPLY(a_cnt_bound, clk, rst_n, 1'b1,
    cnt_r <= usbcfg_pkg::FIFO_CNT_W'(usbcfg_pkg::FIFO_DEPTH), "result queue overflow")
  `USBCFG_ASSERT_IMPLY(a_push_room, clk, rst_n, push.num != 2'd0, room,
    "records pushed without room")
  `USBCFG_ASSERT_IMPLY(a_pair_last, clk, rst_n, push.num == 2'd2,
    !push.rec_a.last && push.rec_b.last, "last flag wrong on a record pair")
  `USBCFG_ASSERT_NEXT(a_pop_count, clk, rst_n, do_pop && push.num == 2'd0,
    cnt_r == $past(cnt_r) - usbcfg_pkg::FIFO_CNT_W'(1), "queue count did not drop on pop")

endmodule
